### design/pwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwf_pkg
// Shared types, widths and codes for the polyline waypoint follower.
// ----------------------------------------------------------------------------
package pwf_pkg;

    localparam int MAX_POINTS_DEF = 16;

    localparam int FUNC_W  = 3;
    localparam int PIDX_W  = 4;
    localparam int COORD_W = 32;
    localparam int DT_W    = 24;
    localparam int IDENT_W = 32;
    localparam int SPEED_W = 24;
    localparam int LEN_W   = 5;
    localparam int VEL_W   = 25;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [FUNC_W-1:0] FUNC_LOAD      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INIT      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_START     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_STOP      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_INTERCEPT = 3'd5;

    localparam logic [MODE_W-1:0] MODE_READY       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FLYING      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPLETED   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INTERCEPTED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTE_LENGTH = 2'd1;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 24'd256;

endpackage

### design/pwf_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwf_intf
// Handshake channels of the follower: items in, results out, register writes.
// ----------------------------------------------------------------------------
interface pwf_item_if;
    import pwf_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic [PIDX_W-1:0]         point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [DT_W-1:0]           delta_time;
    logic [IDENT_W-1:0]        target_ident;
    modport source (output valid, func, point_index, coord_x, coord_y, coord_z,
                    delta_time, target_ident, input ready);
    modport sink (input valid, func, point_index, coord_x, coord_y, coord_z,
                  delta_time, target_ident, output ready);
endinterface

interface pwf_result_if;
    import pwf_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic [MODE_W-1:0]         motion_state;
    logic                      is_active;
    logic                      is_ready_set;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [VEL_W-1:0]   vel_x;
    logic signed [VEL_W-1:0]   vel_y;
    logic signed [VEL_W-1:0]   vel_z;
    logic [LEN_W-1:0]          next_point;
    logic [IDENT_W-1:0]        ident_out;
    modport source (output valid, accepted, motion_state, is_active, is_ready_set,
                    pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, next_point,
                    ident_out, input ready);
    modport sink (input valid, accepted, motion_state, is_active, is_ready_set,
                  pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, next_point,
                  ident_out, output ready);
endinterface

interface pwf_cfg_if;
    import pwf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### design/polyline_waypoint_follower_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_waypoint_follower_top
// Constant-speed follower of a loaded 3D polyline, one transaction at a time.
// ----------------------------------------------------------------------------
// The block takes one item transaction at a time and returns exactly one
// result transaction for it, showing the state after the item. Load, start,
// stop and intercept items go from the execute state straight to the done
// state, and an accepted initialize also passes two states that read slot
// zero. An advance item works on one segment after another: for each it
// forms the squared length and its square root, then runs up to six divisions
// (three for the velocity and three for the position step) through the
// shared divider. A new item is taken while the previous result still waits
// in the output register. The waypoint store is a memory with a registered
// read port; slots that were never loaded read as whatever they hold.
// Register writes are always taken.
// ----------------------------------------------------------------------------
module polyline_waypoint_follower_top #(
    parameter int MAX_POINTS = pwf_pkg::MAX_POINTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pwf_item_if.sink     item,
    pwf_result_if.source result,
    pwf_cfg_if.sink      cfg
);
    import pwf_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_EXEC, S_INIT0, S_INIT1,
        A_REM, A_REM2, A_CHK, A_DIFF, A_SQ, A_ACC, A_SQRT0, A_SQRTW, A_DIST,
        A_VM, A_VD, A_VW, A_TRV, A_PM, A_PD, A_PW, S_DONE
    } state_t;

    state_t state_reg;

    // Registers written through the configuration channel.
    logic [SPEED_W-1:0] speed_reg;
    logic [LEN_W-1:0]   route_len_reg;

    // Latched item fields.
    logic [FUNC_W-1:0]         func_reg;
    logic [PIDX_W-1:0]         pidx_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [DT_W-1:0]           dt_reg;
    logic [IDENT_W-1:0]        ident_in_reg;

    // Architectural state.
    logic signed [COORD_W-1:0] pos_reg [3];
    logic signed [VEL_W-1:0]   vel_reg [3];
    logic [LEN_W-1:0]          next_idx_reg;
    logic [MODE_W-1:0]         mode_reg;
    logic                      init_reg;
    logic                      active_reg;
    logic [IDENT_W-1:0]        ident_reg;
    logic                      acc_reg;

    // Working registers of the advance sequence.
    logic [31:0]  rem_reg;
    logic [32:0]  mag_reg [3];
    logic         neg_reg [3];
    logic         k_reg;
    logic [63:0]  sum_reg;
    logic [32:0]  dist_reg;
    logic [31:0]  travel_reg;
    logic [1:0]   ax_reg;
    logic [65:0]  prod_reg;

    // Waypoint memory with a registered read port.
    logic signed [COORD_W-1:0] wpx_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] wpy_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] wpz_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] wp_rd_reg [3];
    logic [IDX_W-1:0]          rd_addr;
    logic                      wr_en;

    // Output register.
    logic                      out_valid_reg;
    logic                      o_acc_reg;
    logic [MODE_W-1:0]         o_mode_reg;
    logic                      o_active_reg;
    logic                      o_init_reg;
    logic signed [COORD_W-1:0] o_pos_reg [3];
    logic signed [VEL_W-1:0]   o_vel_reg [3];
    logic [LEN_W-1:0]          o_next_reg;
    logic [IDENT_W-1:0]        o_ident_reg;

    logic [LEN_W-1:0]  eff_len;
    logic              pidx_ok;
    logic [32:0]       mul_a, mul_b;
    logic [31:0]       sq_op;
    logic              div_start, div_done;
    logic [63:0]       div_q;
    logic              sqrt_start, sqrt_done;
    logic [31:0]       sqrt_root;
    logic signed [32:0] diff [3];
    logic [32:0]       dmag [3];
    logic [23:0]       vclamp;
    logic [33:0]       pos_new;
    logic [31:0]       travel_c;
    logic              out_free;

    assign eff_len = (32'(route_len_reg) > MAX_POINTS) ? LEN_W'(MAX_POINTS)
                                                       : route_len_reg;
    assign pidx_ok = 32'(pidx_reg) < MAX_POINTS;
    assign out_free = !out_valid_reg || result.ready;

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    // Initialize reads slot zero; everything else reads the waypoint ahead.
    assign rd_addr = (state_reg == S_INIT0) ? IDX_W'(0) : IDX_W'(next_idx_reg);
    assign wr_en   = (state_reg == S_EXEC) && (func_reg == FUNC_LOAD) && pidx_ok;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wpx_mem[IDX_W'(pidx_reg)] <= cx_reg;
            wpy_mem[IDX_W'(pidx_reg)] <= cy_reg;
            wpz_mem[IDX_W'(pidx_reg)] <= cz_reg;
        end
        wp_rd_reg[0] <= wpx_mem[rd_addr];
        wp_rd_reg[1] <= wpy_mem[rd_addr];
        wp_rd_reg[2] <= wpz_mem[rd_addr];
    end

    // Offsets to the waypoint ahead, all three axes side by side.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = 33'(wp_rd_reg[i]) - 33'(pos_reg[i]);
            dmag[i] = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
        end
    end

    // Operand selection for the one shared multiplier.
    assign sq_op = k_reg ? mag_reg[ax_reg][32:1] : mag_reg[ax_reg][31:0];

    always_comb
    begin
        case (state_reg)
            A_REM:
            begin
                mul_a = 33'(speed_reg);
                mul_b = 33'(dt_reg);
            end
            A_SQ:
            begin
                mul_a = 33'(sq_op);
                mul_b = 33'(sq_op);
            end
            A_VM:
            begin
                mul_a = mag_reg[ax_reg];
                mul_b = 33'(speed_reg);
            end
            A_PM:
            begin
                mul_a = mag_reg[ax_reg];
                mul_b = 33'(travel_reg);
            end
            default:
            begin
                mul_a = 33'd0;
                mul_b = 33'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign div_start  = (state_reg == A_VD) || (state_reg == A_PD);
    assign sqrt_start = (state_reg == A_SQRT0);

    pwf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[63:0]),
        .divisor  (dist_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    pwf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign vclamp   = (div_q > 64'(speed_reg)) ? speed_reg : div_q[23:0];
    assign pos_new  = neg_reg[ax_reg]
                    ? 34'(pos_reg[ax_reg]) - {1'b0, div_q[32:0]}
                    : 34'(pos_reg[ax_reg]) + {1'b0, div_q[32:0]};
    assign travel_c = (33'(rem_reg) < dist_reg) ? rem_reg : dist_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            speed_reg     <= SPEED_RESET;
            route_len_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
            next_idx_reg  <= '0;
            mode_reg      <= MODE_READY;
            init_reg      <= 1'b0;
            active_reg    <= 1'b0;
            ident_reg     <= '0;
            acc_reg       <= 1'b0;
            ax_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_TRAVEL_SPEED: speed_reg     <= cfg.data;
                    REG_ROUTE_LENGTH: route_len_reg <= cfg.data[LEN_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        func_reg     <= item.func;
                        pidx_reg     <= item.point_index;
                        cx_reg       <= item.coord_x;
                        cy_reg       <= item.coord_y;
                        cz_reg       <= item.coord_z;
                        dt_reg       <= item.delta_time;
                        ident_in_reg <= item.target_ident;
                        state_reg    <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    acc_reg   <= 1'b0;
                    state_reg <= S_DONE;
                    case (func_reg)
                        FUNC_LOAD:
                        begin
                            acc_reg <= pidx_ok;
                        end
                        FUNC_INIT:
                        begin
                            if (speed_reg != '0 && eff_len >= LEN_W'(2))
                            begin
                                state_reg <= S_INIT0;
                            end
                        end
                        FUNC_START:
                        begin
                            if (init_reg && mode_reg != MODE_INTERCEPTED
                                && mode_reg != MODE_COMPLETED)
                            begin
                                mode_reg   <= MODE_FLYING;
                                active_reg <= 1'b1;
                                acc_reg    <= 1'b1;
                            end
                        end
                        FUNC_STOP:
                        begin
                            active_reg <= 1'b0;
                            for (int i = 0; i < 3; i++)
                            begin
                                vel_reg[i] <= '0;
                            end
                            if (init_reg && mode_reg == MODE_FLYING)
                            begin
                                mode_reg <= MODE_READY;
                            end
                            acc_reg <= 1'b1;
                        end
                        FUNC_ADVANCE:
                        begin
                            if (active_reg && dt_reg != '0)
                            begin
                                acc_reg   <= 1'b1;
                                state_reg <= A_REM;
                            end
                        end
                        FUNC_INTERCEPT:
                        begin
                            if (init_reg)
                            begin
                                active_reg <= 1'b0;
                                for (int i = 0; i < 3; i++)
                                begin
                                    vel_reg[i] <= '0;
                                end
                                mode_reg <= MODE_INTERCEPTED;
                                acc_reg  <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_INIT0:
                begin
                    state_reg <= S_INIT1;
                end
                S_INIT1:
                begin
                    ident_reg    <= ident_in_reg;
                    next_idx_reg <= LEN_W'(1);
                    for (int i = 0; i < 3; i++)
                    begin
                        pos_reg[i] <= wp_rd_reg[i];
                        vel_reg[i] <= '0;
                    end
                    mode_reg   <= MODE_READY;
                    init_reg   <= 1'b1;
                    active_reg <= 1'b0;
                    acc_reg    <= 1'b1;
                    state_reg  <= S_DONE;
                end
                A_REM:
                begin
                    state_reg <= A_REM2;
                end
                A_REM2:
                begin
                    // A 24 by 24 product shifted down by 16 always fits 32 bits.
                    rem_reg   <= prod_reg[47:16];
                    state_reg <= A_CHK;
                end
                A_CHK:
                begin
                    if (rem_reg > 32'd1 && next_idx_reg < eff_len)
                    begin
                        state_reg <= A_DIFF;
                    end
                    else
                    begin
                        if (next_idx_reg >= eff_len)
                        begin
                            active_reg <= 1'b0;
                            for (int i = 0; i < 3; i++)
                            begin
                                vel_reg[i] <= '0;
                            end
                            mode_reg <= MODE_COMPLETED;
                        end
                        state_reg <= S_DONE;
                    end
                end
                A_DIFF:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= dmag[i];
                        neg_reg[i] <= diff[i][32];
                    end
                    // Halve every axis when one offset reaches 2^31 so that
                    // the sum of squares stays inside 64 bits.
                    k_reg     <= (dmag[0][32:31] != 2'b00) || (dmag[1][32:31] != 2'b00)
                                 || (dmag[2][32:31] != 2'b00);
                    sum_reg   <= '0;
                    ax_reg    <= '0;
                    state_reg <= A_SQ;
                end
                A_SQ:
                begin
                    state_reg <= A_ACC;
                end
                A_ACC:
                begin
                    sum_reg <= sum_reg + prod_reg[63:0];
                    if (ax_reg == 2'd2)
                    begin
                        state_reg <= A_SQRT0;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= A_SQ;
                    end
                end
                A_SQRT0:
                begin
                    state_reg <= A_SQRTW;
                end
                A_SQRTW:
                begin
                    if (sqrt_done)
                    begin
                        dist_reg  <= k_reg ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};
                        state_reg <= A_DIST;
                    end
                end
                A_DIST:
                begin
                    ax_reg <= '0;
                    if (dist_reg <= 33'd1)
                    begin
                        // Already on the waypoint: snap and move on.
                        for (int i = 0; i < 3; i++)
                        begin
                            pos_reg[i] <= wp_rd_reg[i];
                        end
                        next_idx_reg <= next_idx_reg + LEN_W'(1);
                        state_reg    <= A_CHK;
                    end
                    else
                    begin
                        state_reg <= A_VM;
                    end
                end
                A_VM:
                begin
                    state_reg <= A_VD;
                end
                A_VD:
                begin
                    state_reg <= A_VW;
                end
                A_VW:
                begin
                    if (div_done)
                    begin
                        vel_reg[ax_reg] <= neg_reg[ax_reg]
                                         ? -$signed({1'b0, vclamp})
                                         : $signed({1'b0, vclamp});
                        if (ax_reg == 2'd2)
                        begin
                            state_reg <= A_TRV;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= A_VM;
                        end
                    end
                end
                A_TRV:
                begin
                    travel_reg <= travel_c;
                    ax_reg     <= '0;
                    if (34'(travel_c) + 34'd1 >= 34'(dist_reg))
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            pos_reg[i] <= wp_rd_reg[i];
                        end
                        next_idx_reg <= next_idx_reg + LEN_W'(1);
                        rem_reg      <= rem_reg - travel_c;
                        state_reg    <= A_CHK;
                    end
                    else
                    begin
                        state_reg <= A_PM;
                    end
                end
                A_PM:
                begin
                    state_reg <= A_PD;
                end
                A_PD:
                begin
                    state_reg <= A_PW;
                end
                A_PW:
                begin
                    if (div_done)
                    begin
                        pos_reg[ax_reg] <= $signed(pos_new[31:0]);
                        if (ax_reg == 2'd2)
                        begin
                            rem_reg   <= rem_reg - travel_reg;
                            state_reg <= A_CHK;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= A_PM;
                        end
                    end
                end
                S_DONE:
                begin
                    // Hand the snapshot to the output register once it is free.
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        o_acc_reg     <= acc_reg;
                        o_mode_reg    <= mode_reg;
                        o_active_reg  <= active_reg;
                        o_init_reg    <= init_reg;
                        for (int i = 0; i < 3; i++)
                        begin
                            o_pos_reg[i] <= pos_reg[i];
                            o_vel_reg[i] <= vel_reg[i];
                        end
                        o_next_reg  <= next_idx_reg;
                        o_ident_reg <= ident_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.accepted     = o_acc_reg;
    assign result.motion_state = o_mode_reg;
    assign result.is_active    = o_active_reg;
    assign result.is_ready_set = o_init_reg;
    assign result.pos_x        = o_pos_reg[0];
    assign result.pos_y        = o_pos_reg[1];
    assign result.pos_z        = o_pos_reg[2];
    assign result.vel_x        = o_vel_reg[0];
    assign result.vel_y        = o_vel_reg[1];
    assign result.vel_z        = o_vel_reg[2];
    assign result.next_point   = o_next_reg;
    assign result.ident_out    = o_ident_reg;
endmodule

### design/pwf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwf_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module pwf_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] num_reg;
    logic [32:0] den_reg;
    logic [33:0] rem_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] shifted;
    logic        fits;

    assign shifted = {rem_reg[32:0], num_reg[63]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
                num_reg  <= dividend;
                den_reg  <= divisor;
                rem_reg  <= 34'd0;
            end
            else if (busy_reg)
            begin
                // Quotient bits are shifted in where the dividend leaves.
                rem_reg <= fits ? shifted - {1'b0, den_reg} : shifted;
                num_reg <= {num_reg[62:0], fits};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;
endmodule

### design/pwf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwf_sqrt
// Integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module pwf_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] partial;
    logic [33:0] trial;
    logic        fits;

    assign partial = {rem_reg[31:0], rad_reg[63:62]};
    assign trial   = {root_reg, 2'b01};
    assign fits    = partial >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
                rad_reg  <= radicand;
                rem_reg  <= 34'd0;
                root_reg <= 32'd0;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? partial - trial : partial;
                root_reg <= {root_reg[30:0], fits};
                rad_reg  <= {rad_reg[61:0], 2'b00};
                cnt_reg  <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
